// ===== hdl/pmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_pkg
// shared types, codes and helpers of the maze carver
// ----------------------------------------------------------------------------
package pmc_pkg;

	localparam int USE_W = 9;    // holds grid size in use, up to 256

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic [1:0] CELL_UNVISITED = 2'd0;
	localparam logic [1:0] CELL_FRONTIER  = 2'd1;
	localparam logic [1:0] CELL_IN_MAZE   = 2'd2;

	localparam logic [2:0] WALL_LEFT   = 3'd0;
	localparam logic [2:0] WALL_RIGHT  = 3'd1;
	localparam logic [2:0] WALL_BOTTOM = 3'd2;
	localparam logic [2:0] WALL_TOP    = 3'd3;
	localparam logic [2:0] WALL_NONE   = 3'd4;

	localparam logic [1:0] STAT_CARVED = 2'd0;
	localparam logic [1:0] STAT_PLACED = 2'd1;
	localparam logic [1:0] STAT_IDLE   = 2'd2;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	typedef struct packed {
		logic       load_in;
		logic       clr_start;
		logic       clr_step;
		logic       cnt_clear;
		logic       set_started;
		logic       mod_init;
		logic       mod_step;
		logic       fr_take;
		logic       maze_add;
		logic       nb_add;
		logic       wall_clear;
		logic       wall_chk;
		logic       sh_start;
		logic       sh_step;
		logic       fc_dec;
		logic       out_load;
		logic [1:0] nb_dir;
		logic [1:0] out_kind;
	} pmc_cmd_t;

	typedef struct packed {
		logic op;
		logic idle_step;
		logic fc_small;
		logic clr_last;
		logic mod_last;
		logic sh_done;
		logic out_free;
	} pmc_sts_t;

	// frontier append order: up, down, left, right
	function automatic logic [1:0] add_dir(input logic [1:0] k);
		add_dir = k;
	endfunction

	// wall search order: left, down, right, up
	function automatic logic [1:0] wall_dir(input logic [1:0] k);
		logic [1:0] d;
		unique case (k)
			2'd0: d = DIR_LEFT;
			2'd1: d = DIR_DOWN;
			2'd2: d = DIR_RIGHT;
			default: d = DIR_UP;
		endcase
		wall_dir = d;
	endfunction

	function automatic logic [2:0] wall_code(input logic [1:0] d);
		logic [2:0] w;
		unique case (d)
			DIR_LEFT:  w = WALL_LEFT;
			DIR_DOWN:  w = WALL_BOTTOM;
			DIR_RIGHT: w = WALL_RIGHT;
			default:   w = WALL_TOP;
		endcase
		wall_code = w;
	endfunction

endpackage

// ===== hdl/prim_maze_carver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prim_maze_carver_top
// randomized prim maze carver: at most one cell added to the maze per step word
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | opcode, start_row, start_col, random_value
//  out     | out_valid / out_ready| cell_row, cell_col, opened_wall, status,
//          |                      | maze_done
//  cfg     | cfg_wr_en            | cfg_index, cfg_data
//
// start word: clears the cell store one entry a cycle, then places the cell
//   and scans its neighbors
// step word: serial modulo over the 16 random bits (skipped with under two frontier
//   entries), neighbor and wall checks, then the order-keeping removal moves
//   the frontier entries behind the drawn one, one entry a cycle
// reset clears counters and control; store contents are rebuilt by start
// a new word is taken while a finished result still waits in the output
//   register; the carver stalls only if a second result is ready before then
// ----------------------------------------------------------------------------
module prim_maze_carver_top #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [4:0]  start_row,
	input  logic [4:0]  start_col,
	input  logic [15:0] random_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  cell_row,
	output logic [4:0]  cell_col,
	output logic [2:0]  opened_wall,
	output logic [1:0]  status,
	output logic        maze_done,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data
);
	import pmc_pkg::*;

	// commands from sequencer, status back from datapath
	pmc_cmd_t cmd;
	pmc_sts_t sts;

	pmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// stores, counters, modulo unit and output register
	pmc_dpath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.opcode       (opcode),
		.start_row    (start_row),
		.start_col    (start_col),
		.random_value (random_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cell_row     (cell_row),
		.cell_col     (cell_col),
		.opened_wall  (opened_wall),
		.status       (status),
		.maze_done    (maze_done)
	);
endmodule

// ===== hdl/pmc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module pmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/pmc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_ctrl
// sequencer for start and step words of the maze carver
// ----------------------------------------------------------------------------
module pmc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output pmc_pkg::pmc_cmd_t cmd,
	input  pmc_pkg::pmc_sts_t sts
);
	import pmc_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DEC     = 4'd1;
	localparam logic [3:0] S_CLR     = 4'd2;
	localparam logic [3:0] S_MOD     = 4'd3;
	localparam logic [3:0] S_FR_RD   = 4'd4;
	localparam logic [3:0] S_FR_TAKE = 4'd5;
	localparam logic [3:0] S_ADD     = 4'd6;
	localparam logic [3:0] S_NB_RD   = 4'd7;
	localparam logic [3:0] S_NB_WR   = 4'd8;
	localparam logic [3:0] S_WL_RD   = 4'd9;
	localparam logic [3:0] S_WL_CHK  = 4'd10;
	localparam logic [3:0] S_SHIFT   = 4'd11;
	localparam logic [3:0] S_FIN     = 4'd12;

	logic [3:0] state_q, state_d;
	logic [1:0] k_q, k_d;
	logic [1:0] kind_q, kind_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		kind_d  = kind_q;
		cmd     = '0;
		cmd.out_kind = kind_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.op == OP_START) begin
					cmd.clr_start   = 1'b1;
					cmd.cnt_clear   = 1'b1;
					cmd.set_started = 1'b1;
					kind_d          = STAT_PLACED;
					state_d         = S_CLR;
				end else if (sts.idle_step) begin
					kind_d  = STAT_IDLE;
					state_d = S_FIN;
				end else begin
					cmd.mod_init = 1'b1;
					kind_d       = STAT_CARVED;
					state_d      = sts.fc_small ? S_FR_RD : S_MOD;
				end
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_ADD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_d = S_FR_RD;
				end
			end
			S_FR_RD: begin
				state_d = S_FR_TAKE;
			end
			S_FR_TAKE: begin
				cmd.fr_take = 1'b1;
				state_d     = S_ADD;
			end
			S_ADD: begin
				cmd.maze_add   = 1'b1;
				cmd.wall_clear = 1'b1;
				k_d            = 2'd0;
				state_d        = S_NB_RD;
			end
			S_NB_RD: begin
				cmd.nb_dir = add_dir(k_q);
				state_d    = S_NB_WR;
			end
			S_NB_WR: begin
				cmd.nb_dir = add_dir(k_q);
				cmd.nb_add = 1'b1;
				k_d        = k_q + 2'd1;
				if (k_q == 2'd3) begin
					state_d = (sts.op == OP_START) ? S_FIN : S_WL_RD;
				end else begin
					state_d = S_NB_RD;
				end
			end
			S_WL_RD: begin
				cmd.nb_dir = wall_dir(k_q);
				state_d    = S_WL_CHK;
			end
			S_WL_CHK: begin
				cmd.nb_dir   = wall_dir(k_q);
				cmd.wall_chk = 1'b1;
				k_d          = k_q + 2'd1;
				if (k_q == 2'd3) begin
					cmd.sh_start = 1'b1;
					state_d      = S_SHIFT;
				end else begin
					state_d = S_WL_RD;
				end
			end
			S_SHIFT: begin
				cmd.sh_step = 1'b1;
				if (sts.sh_done) begin
					cmd.fc_dec = 1'b1;
					state_d    = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= 2'd0;
			kind_q  <= STAT_IDLE;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			kind_q  <= kind_d;
		end
	end
endmodule

// ===== hdl/pmc_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_dpath
// cell and frontier stores, counters, serial modulo and output register
// ----------------------------------------------------------------------------
module pmc_dpath #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pmc_pkg::pmc_cmd_t cmd,
	output pmc_pkg::pmc_sts_t sts,
	input  logic              cfg_wr_en,
	input  logic              cfg_index,
	input  logic [5:0]        cfg_data,
	input  logic              opcode,
	input  logic [4:0]        start_row,
	input  logic [4:0]        start_col,
	input  logic [15:0]       random_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [4:0]        cell_row,
	output logic [4:0]        cell_col,
	output logic [2:0]        opened_wall,
	output logic [1:0]        status,
	output logic              maze_done
);
	import pmc_pkg::*;

	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int FCW   = $clog2(CELLS + 1);
	localparam int PW    = RW + CW;

	logic [5:0]       rows_cfg_q, cols_cfg_q;
	logic [USE_W-1:0] rows_use, cols_use;
	logic             op_q;
	logic [RW-1:0]    r_q;
	logic [CW-1:0]    c_q;
	logic [15:0]      rnd_q;
	logic [FCW-1:0]   fc_q, mc_q;
	logic             started_q;
	logic [AW-1:0]    clr_q;
	logic [FCW-1:0]   rem_q;
	logic [15:0]      div_q;
	logic [3:0]       mcnt_q;
	logic [FCW-1:0]   ptr_q;
	logic             pend_q;
	logic [AW-1:0]    wa_q;
	logic [2:0]       wall_q;
	logic             done;

	// config registers and sizes in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= 6'd32;
			cols_cfg_q <= 6'd32;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_ROWS) begin
				rows_cfg_q <= cfg_data;
			end else begin
				cols_cfg_q <= cfg_data;
			end
		end
	end

	always_comb begin
		if (rows_cfg_q == 6'd0) begin
			rows_use = USE_W'(1);
		end else if (USE_W'(rows_cfg_q) > USE_W'(MAX_ROWS)) begin
			rows_use = USE_W'(MAX_ROWS);
		end else begin
			rows_use = USE_W'(rows_cfg_q);
		end
		if (cols_cfg_q == 6'd0) begin
			cols_use = USE_W'(1);
		end else if (USE_W'(cols_cfg_q) > USE_W'(MAX_COLS)) begin
			cols_use = USE_W'(MAX_COLS);
		end else begin
			cols_use = USE_W'(cols_cfg_q);
		end
	end

	assign done = (2*USE_W)'(mc_q) >= ((2*USE_W)'(rows_use) * (2*USE_W)'(cols_use));

	// start cell saturation
	logic [USE_W-1:0] sat_r, sat_c;
	always_comb begin
		sat_r = USE_W'(start_row);
		sat_c = USE_W'(start_col);
		if (sat_r >= rows_use) sat_r = rows_use - USE_W'(1);
		if (sat_c >= cols_use) sat_c = cols_use - USE_W'(1);
	end

	// neighbor of the current cell, must lie inside the grid in use
	logic [USE_W-1:0] rw, cw, nr, nc;
	logic             nb_ok;
	logic [AW-1:0]    nb_addr, cur_addr;
	always_comb begin
		rw = USE_W'(r_q);
		cw = USE_W'(c_q);
		nr = rw;
		nc = cw;
		unique case (cmd.nb_dir)
			DIR_UP: begin
				nb_ok = (rw != '0);
				nr    = rw - USE_W'(1);
			end
			DIR_DOWN: begin
				nb_ok = 1'b1;
				nr    = rw + USE_W'(1);
			end
			DIR_LEFT: begin
				nb_ok = (cw != '0);
				nc    = cw - USE_W'(1);
			end
			default: begin
				nb_ok = 1'b1;
				nc    = cw + USE_W'(1);
			end
		endcase
		nb_ok    = nb_ok && (nr < rows_use) && (nc < cols_use);
		nb_addr  = AW'(32'(nr) * 32'(MAX_COLS) + 32'(nc));
		cur_addr = AW'(32'(r_q) * 32'(MAX_COLS) + 32'(c_q));
	end

	// cell status store
	logic          st_we;
	logic [AW-1:0] st_waddr;
	logic [1:0]    st_wdata, st_rdata;
	logic          nb_add_go;

	assign nb_add_go = cmd.nb_add && nb_ok && (st_rdata == CELL_UNVISITED)
		&& (32'(fc_q) < CELLS);

	always_comb begin
		st_we    = 1'b0;
		st_waddr = nb_addr;
		st_wdata = CELL_FRONTIER;
		if (cmd.clr_step) begin
			st_we    = 1'b1;
			st_waddr = clr_q;
			st_wdata = CELL_UNVISITED;
		end else if (cmd.maze_add) begin
			st_we    = 1'b1;
			st_waddr = cur_addr;
			st_wdata = CELL_IN_MAZE;
		end else if (nb_add_go) begin
			st_we = 1'b1;
		end
	end

	pmc_ram #(.WIDTH(2), .DEPTH(CELLS)) u_status_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (nb_addr),
		.rdata (st_rdata)
	);

	// frontier list store, entries packed as {row, col}
	logic          fr_we;
	logic [AW-1:0] fr_waddr, fr_raddr;
	logic [PW-1:0] fr_wdata, fr_rdata;
	logic          rd_go;

	assign rd_go    = ptr_q < fc_q;
	assign fr_we    = nb_add_go || (cmd.sh_step && pend_q);
	assign fr_waddr = nb_add_go ? fc_q[AW-1:0] : wa_q;
	assign fr_wdata = nb_add_go ? {RW'(nr), CW'(nc)} : fr_rdata;
	assign fr_raddr = cmd.sh_step ? ptr_q[AW-1:0] : rem_q[AW-1:0];

	pmc_ram #(.WIDTH(PW), .DEPTH(CELLS)) u_frontier_ram (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_waddr),
		.wdata (fr_wdata),
		.raddr (fr_raddr),
		.rdata (fr_rdata)
	);

	// restoring modulo, one dividend bit a cycle
	logic [FCW:0] mod_t;
	assign mod_t = {rem_q, div_q[15]};

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= opcode;
			rnd_q <= random_value;
			r_q   <= RW'(sat_r);
			c_q   <= CW'(sat_c);
		end else if (cmd.fr_take) begin
			r_q <= fr_rdata[PW-1:CW];
			c_q <= fr_rdata[CW-1:0];
		end
		if (cmd.clr_start) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + AW'(1);
		end
		if (cmd.mod_init) begin
			rem_q  <= '0;
			div_q  <= rnd_q;
			mcnt_q <= 4'd0;
		end else if (cmd.mod_step) begin
			if (mod_t >= {1'b0, fc_q}) begin
				rem_q <= FCW'(mod_t - {1'b0, fc_q});
			end else begin
				rem_q <= mod_t[FCW-1:0];
			end
			div_q  <= {div_q[14:0], 1'b0};
			mcnt_q <= mcnt_q + 4'd1;
		end
		if (cmd.sh_step && rd_go) begin
			wa_q <= AW'(ptr_q - FCW'(1));
		end
		if (cmd.wall_clear) begin
			wall_q <= WALL_NONE;
		end else if (cmd.wall_chk && (wall_q == WALL_NONE) && nb_ok
				&& (st_rdata >= CELL_IN_MAZE)) begin
			wall_q <= wall_code(cmd.nb_dir);
		end
		if (cmd.out_load) begin
			cell_row    <= (cmd.out_kind == STAT_IDLE) ? 5'd0 : 5'(r_q);
			cell_col    <= (cmd.out_kind == STAT_IDLE) ? 5'd0 : 5'(c_q);
			opened_wall <= (cmd.out_kind == STAT_CARVED) ? wall_q : WALL_NONE;
			status      <= cmd.out_kind;
			maze_done   <= started_q && done;
		end
	end

	// control state: counters, shift pointer, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q      <= '0;
			mc_q      <= '0;
			started_q <= 1'b0;
			ptr_q     <= '0;
			pend_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.cnt_clear) begin
				fc_q <= '0;
			end else if (nb_add_go) begin
				fc_q <= fc_q + FCW'(1);
			end else if (cmd.fc_dec) begin
				fc_q <= fc_q - FCW'(1);
			end
			if (cmd.cnt_clear) begin
				mc_q <= '0;
			end else if (cmd.maze_add) begin
				mc_q <= mc_q + FCW'(1);
			end
			if (cmd.set_started) begin
				started_q <= 1'b1;
			end
			if (cmd.sh_start) begin
				ptr_q  <= rem_q + FCW'(1);
				pend_q <= 1'b0;
			end else if (cmd.sh_step) begin
				if (rd_go) begin
					ptr_q <= ptr_q + FCW'(1);
				end
				pend_q <= rd_go;
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.op        = op_q;
		sts.idle_step = !started_q || done || (fc_q == '0);
		sts.fc_small  = (fc_q >> 1) == '0;
		sts.clr_last  = (clr_q == AW'(CELLS - 1));
		sts.mod_last  = (mcnt_q == 4'd15);
		sts.sh_done   = !rd_go && !pend_q;
		sts.out_free  = !out_valid || out_ready;
	end
endmodule

// ===== test/prim_maze_carver_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prim_maze_carver_top_test
// self-checking bench for the prim maze carver: a carve predictor tracks the
// cell store and frontier list, every output word is compared in order
// ----------------------------------------------------------------------------
module prim_maze_carver_top_test;
	import pmc_pkg::*;

	localparam int GRID_MAX  = 32;
	localparam int CELLS     = GRID_MAX * GRID_MAX;
	localparam int WORDS_TGT = 540;

	typedef struct {
		logic [4:0] row;
		logic [4:0] col;
		logic [2:0] wall;
		logic [1:0] stat;
		logic       done;
	} carve_word_t;

	// carve predictor and store of expected output words
	class carve_board;
		logic [5:0]  rows_reg;
		logic [5:0]  cols_reg;
		logic [1:0]  cell_st[CELLS];
		int          frontier[$];
		int          in_maze_n;
		bit          started;
		carve_word_t expected[$];
		int          errors;

		function new();
			rows_reg = 6'd32;
			cols_reg = 6'd32;
			foreach (cell_st[i]) cell_st[i] = CELL_UNVISITED;
			in_maze_n = 0;
			started = 0;
			errors = 0;
		endfunction

		function void set_reg(logic idx, logic [5:0] val);
			if (idx == REG_ROWS) rows_reg = val;
			else cols_reg = val;
		endfunction

		function int rows_used();
			if (rows_reg == 6'd0) return 1;
			return (int'(rows_reg) > GRID_MAX) ? GRID_MAX : int'(rows_reg);
		endfunction

		function int cols_used();
			if (cols_reg == 6'd0) return 1;
			return (int'(cols_reg) > GRID_MAX) ? GRID_MAX : int'(cols_reg);
		endfunction

		function bit complete();
			return in_maze_n >= rows_used() * cols_used();
		endfunction

		function bit on_grid(int r, int c);
			return r >= 0 && c >= 0 && r < rows_used() && c < cols_used();
		endfunction

		function void add_frontier(int r, int c);
			int idx;
			if (!on_grid(r, c)) return;
			idx = r * GRID_MAX + c;
			if (cell_st[idx] != CELL_UNVISITED) return;
			if (frontier.size() >= CELLS) return;
			cell_st[idx] = CELL_FRONTIER;
			frontier.push_back(idx);
		endfunction

		// neighbors join the frontier in the order up, down, left, right
		function void carve_cell(int r, int c);
			cell_st[r * GRID_MAX + c] = CELL_IN_MAZE;
			in_maze_n++;
			add_frontier(r - 1, c);
			add_frontier(r + 1, c);
			add_frontier(r, c - 1);
			add_frontier(r, c + 1);
		endfunction

		function bit carved_at(int r, int c);
			if (!on_grid(r, c)) return 0;
			return cell_st[r * GRID_MAX + c] >= CELL_IN_MAZE;
		endfunction

		// wall search order: left, down, right, up
		function logic [2:0] open_wall(int r, int c);
			if (carved_at(r, c - 1)) return WALL_LEFT;
			if (carved_at(r + 1, c)) return WALL_BOTTOM;
			if (carved_at(r, c + 1)) return WALL_RIGHT;
			if (carved_at(r - 1, c)) return WALL_TOP;
			return WALL_NONE;
		endfunction

		function void note_word(logic op, logic [4:0] srow, logic [4:0] scol,
				logic [15:0] rnd);
			carve_word_t w;
			int r, c, pos, idx;
			if (op == OP_START) begin
				r = int'(srow);
				c = int'(scol);
				if (r >= rows_used()) r = rows_used() - 1;
				if (c >= cols_used()) c = cols_used() - 1;
				foreach (cell_st[i]) cell_st[i] = CELL_UNVISITED;
				frontier.delete();
				in_maze_n = 0;
				started = 1;
				carve_cell(r, c);
				w.wall = WALL_NONE;
				w.stat = STAT_PLACED;
			end else if (!started || complete() || frontier.size() == 0) begin
				r = 0;
				c = 0;
				w.wall = WALL_NONE;
				w.stat = STAT_IDLE;
			end else begin
				pos = (frontier.size() < 2) ? 0 : int'(rnd) % frontier.size();
				idx = frontier[pos];
				r = idx / GRID_MAX;
				c = idx % GRID_MAX;
				carve_cell(r, c);
				w.wall = open_wall(r, c);
				frontier.delete(pos);
				w.stat = STAT_CARVED;
			end
			w.row = r[4:0];
			w.col = c[4:0];
			w.done = started && complete();
			expected.push_back(w);
		endfunction

		function void check_word(carve_word_t got);
			carve_word_t exp_w;
			if (expected.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: row %0d col %0d wall %0d status %0d",
						got.row, got.col, got.wall, got.stat);
				return;
			end
			exp_w = expected.pop_front();
			if (got.row != exp_w.row || got.col != exp_w.col || got.wall != exp_w.wall ||
					got.stat != exp_w.stat || got.done != exp_w.done) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp r%0d c%0d w%0d s%0d d%0d, got r%0d c%0d w%0d s%0d d%0d",
						exp_w.row, exp_w.col, exp_w.wall, exp_w.stat, exp_w.done,
						got.row, got.col, got.wall, got.stat, got.done);
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        opcode;
	logic [4:0]  start_row;
	logic [4:0]  start_col;
	logic [15:0] random_value;
	logic        out_valid;
	logic        out_ready = 1'b1;
	logic [4:0]  cell_row;
	logic [4:0]  cell_col;
	logic [2:0]  opened_wall;
	logic [1:0]  status;
	logic        maze_done;
	logic        cfg_wr_en;
	logic        cfg_index;
	logic [5:0]  cfg_data;

	carve_board board;
	int         words_sent;
	bit         quiet;      // no idling on either side while set
	int         sink_hold = 0;

	prim_maze_carver_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .start_row(start_row), .start_col(start_col),
		.random_value(random_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.cell_row(cell_row), .cell_col(cell_col), .opened_wall(opened_wall),
		.status(status), .maze_done(maze_done),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// one generous limit for the whole run
	initial begin
		#15ms;
		$display("prim_maze_carver_top_test: FAIL");
		$finish;
	end

	// output side: random stall per word, checks every accepted word
	always @(posedge clk) begin
		carve_word_t got;
		if (arst_n && out_valid && out_ready) begin
			got.row = cell_row;
			got.col = cell_col;
			got.wall = opened_wall;
			got.stat = status;
			got.done = maze_done;
			board.check_word(got);
			sink_hold = quiet ? 0 : $urandom_range(0, 12);
			out_ready <= (sink_hold == 0);
		end else if (sink_hold != 0) begin
			sink_hold = sink_hold - 1;
			out_ready <= (sink_hold == 0);
		end
	end

	// offer one word after a random gap, return once it is taken
	task automatic push_word(logic op, logic [4:0] r, logic [4:0] c, logic [15:0] rnd);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		start_row <= r;
		start_col <= c;
		random_value <= rnd;
		do @(posedge clk); while (!in_ready);
		board.note_word(op, r, c, rnd);
		words_sent++;
	endtask

	task automatic step_word(logic [15:0] rnd);
		push_word(OP_STEP, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), rnd);
	endtask

	// hold the sender until every expected word is back
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// registers only change with the carver idle
	task automatic set_grid(logic [5:0] rows, logic [5:0] cols);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_ROWS;
		cfg_data <= rows;
		@(posedge clk);
		board.set_reg(REG_ROWS, rows);
		cfg_index <= REG_COLS;
		cfg_data <= cols;
		@(posedge clk);
		board.set_reg(REG_COLS, cols);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [5:0] pick_size();
		if ($urandom_range(0, 9) < 7) return 6'($urandom_range(1, 6));
		return 6'($urandom_range(0, 63));
	endfunction

	initial begin
		int steps;
		board = new();
		words_sent = 0;
		quiet = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_START;
		start_row = '0;
		start_col = '0;
		random_value = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_ROWS;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// step before any start does nothing
		step_word(16'h1234);
		// far corner on the full grid, then draws at both ends of the range
		push_word(OP_START, 5'd31, 5'd31, 16'hffff);
		step_word(16'hffff);
		step_word(16'h0000);
		step_word(16'h8001);

		// zero registers act as a single cell; start saturates and completes at once
		set_grid(6'd0, 6'd0);
		push_word(OP_START, 5'd5, 5'd7, 16'h0);
		step_word(16'h00ff);

		// oversize registers clamp to the full grid
		set_grid(6'd63, 6'd63);
		push_word(OP_START, 5'd0, 5'd0, 16'h0);
		step_word(16'h0000);

		// shrink mid-run: drawn cell lies off the grid, no carved neighbor
		set_grid(6'd32, 6'd32);
		push_word(OP_START, 5'd1, 5'd1, 16'h0);
		set_grid(6'd1, 6'd2);
		step_word(16'h0001);
		step_word(16'h0002);

		// grow mid-run with an empty frontier: nothing to carve
		set_grid(6'd1, 6'd1);
		push_word(OP_START, 5'd3, 5'd3, 16'h0);
		set_grid(6'd1, 6'd4);
		step_word(16'h5555);

		// small grid carved to completion, one extra step after done
		set_grid(6'd2, 6'd3);
		push_word(OP_START, 5'd1, 5'd2, 16'h0);
		repeat (6) step_word(16'($urandom_range(0, 65535)));

		// random phases, mostly whole mazes on small grids
		while (words_sent < WORDS_TGT) begin
			drain();
			quiet = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) != 0) set_grid(pick_size(), pick_size());
			if ($urandom_range(0, 9) != 0)
				push_word(OP_START, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
					16'($urandom_range(0, 65535)));
			steps = board.rows_used() * board.cols_used() + int'($urandom_range(0, 2));
			if (steps > 120) steps = int'($urandom_range(20, 120));
			for (int i = 0; i < steps && words_sent < WORDS_TGT; i++) begin
				if ($urandom_range(0, 19) == 0)
					push_word(OP_START, 5'($urandom_range(0, 31)),
						5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)));
				else
					step_word(16'($urandom_range(0, 65535)));
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("prim_maze_carver_top_test: PASS");
		else
			$display("prim_maze_carver_top_test: FAIL");
		$finish;
	end

endmodule

// ===== prim_maze_carver_top.f =====
hdl/pmc_pkg.sv
hdl/pmc_ram.sv
hdl/pmc_ctrl.sv
hdl/pmc_dpath.sv
hdl/prim_maze_carver_top.sv
test/prim_maze_carver_top_test.sv
